/* rtl/core/upgrade_image_crc_check_top_assert.svh */
// assertion macros for the image crc check block
`ifndef UPGRADE_IMAGE_CRC_CHECK_TOP_ASSERT_SVH
`define UPGRADE_IMAGE_CRC_CHECK_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define UICC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define UICC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/uicc_pkg.sv */
// types, constants and crc step function for the image crc check block
`default_nettype none
package uicc_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [1:0] STATUS_MATCH     = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // control from the sequencer to the crc unit
  typedef struct packed {
    logic init;
    logic en;
  } crc_ctrl_t;

  // one byte of msb-first crc-32, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] crc;
    crc = crc_in ^ {data, 24'd0};
    for (int b = 0; b < 8; b++) begin
      if (crc[31]) begin
        crc = {crc[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[30:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/upgrade_image_crc_check_top.sv */
// Firmware image receiver: stores image bytes and checks the trailing crc-32/mpeg-2 word.
//
// Input channel (in_valid / in_stall): one beat carries write_index, image_length and
// data_byte. The byte is written to the buffer at write_index, clamped to the last entry.
// When the clamped index equals image_length - 1 the image is complete and one result
// beat follows on the output channel (out_valid / out_stall); other beats give none.
// A beat that does not complete the image leaves the input unstalled. A completing beat
// with length 4 or more starts a walk of the buffer through the single ram read port,
// one byte per cycle: bytes 0 .. L-5 go through the crc unit, bytes L-4 .. L-1 form the
// received word. The walk runs through ST_READ and ST_DRAIN, and ST_FINISH registers the
// result; in_stall stays high until it returns to ST_IDLE. Lengths 1 to 3 go straight to
// ST_FINISH and give a too-short result.
// A waiting result does not block new beats; only the next completion waits for it to
// be taken, holding in_stall high until out_stall drops.
// Reset clears the sequencer and the output valid; buffer contents are undefined
// until written and no clearing pass is run.
`default_nettype none
module upgrade_image_crc_check_top #(
  parameter int BUFFER_DEPTH = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] write_index,
  input  wire logic [15:0] image_length,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  status,
  output logic      [31:0] received_crc,
  output logic      [31:0] computed_crc
);
  import uicc_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam logic [16:0] DEPTH_WIDE = 17'(BUFFER_DEPTH);
  localparam logic [15:0] LAST_ENTRY = 16'(BUFFER_DEPTH - 1);

  state_t            state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] last_pos;
  logic [ADDR_W-1:0] crc_end;
  logic              too_short;
  logic              rd_en;
  logic              rd_pending;
  logic              rd_crc;
  logic [7:0]        rd_data;
  logic [31:0]       rx_word;
  logic [31:0]       crc;
  crc_ctrl_t         crc_ctl;
  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic [15:0]       idx_clamped;
  logic              complete;
  logic              is_short;

  // input side: clamp index and detect the completing beat
  assign in_stall    = (state != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign idx_clamped = ({1'b0, write_index} >= DEPTH_WIDE) ? LAST_ENTRY : write_index;
  assign complete    = (image_length != 16'd0) && (idx_clamped == image_length - 16'd1);
  assign is_short    = (image_length < 16'd4);
  assign out_free    = !out_valid || !out_stall;

  uicc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (idx_clamped[ADDR_W-1:0]),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  uicc_crc_unit u_crc (
    .clk       (clk),
    .ctrl      (crc_ctl),
    .data_byte (rd_data),
    .crc       (crc)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ptr        <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      rd_pending <= rd_en;
    end
  end

  // next state, buffer walk and crc control
  always_comb begin
    state_next  = state;
    ptr_next    = ptr;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    crc_ctl     = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && complete) begin
          if (is_short) begin
            state_next = ST_FINISH;
          end else begin
            state_next   = ST_READ;
            ptr_next     = '0;
            crc_ctl.init = 1'b1;
          end
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (ptr == last_pos) begin
          state_next = ST_DRAIN;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    crc_ctl.en = rd_pending && rd_crc;
  end

  // image geometry captured on the completing beat
  always_ff @(posedge clk) begin
    if (in_acc && complete) begin
      last_pos  <= idx_clamped[ADDR_W-1:0];
      crc_end   <= ADDR_W'(image_length - 16'd4);
      too_short <= is_short;
    end
  end

  // tag each read as crc data or trailing word, shift trailing bytes in little-endian
  always_ff @(posedge clk) begin
    rd_crc <= (ptr < crc_end);
    if (rd_pending && !rd_crc) begin
      rx_word <= {rd_data, rx_word[31:8]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (too_short) begin
        status       <= STATUS_TOO_SHORT;
        received_crc <= '0;
        computed_crc <= '0;
      end else begin
        status       <= (crc == rx_word) ? STATUS_MATCH : STATUS_MISMATCH;
        received_crc <= rx_word;
        computed_crc <= crc;
      end
    end
  end

`include "upgrade_image_crc_check_top_assert.svh"

  // the walk never passes the last byte of the image
  `UICC_ASSERT_NOW(a_ptr_bound, clk, rst, state == ST_READ, ptr <= last_pos, "read pointer past image end")
  // read data only arrives while the walk is in progress
  `UICC_ASSERT_NOW(a_rd_window, clk, rst, rd_pending, state == ST_READ || state == ST_DRAIN, "read data outside walk")
  // a short image goes straight to the result stage
  `UICC_ASSERT_NEXT(a_short_path, clk, rst, in_acc && complete && is_short, state == ST_FINISH && too_short, "short image not reported")
  // loading a result always raises the output valid
  `UICC_ASSERT_NEXT(a_out_load, clk, rst, out_load, out_valid, "result load lost")

endmodule
`default_nettype wire

/* rtl/core/uicc_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none
module uicc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/uicc_crc_unit.sv */
// crc register, one image byte folded in per cycle while enabled
`default_nettype none
module uicc_crc_unit (
  input  wire logic                clk,
  input  wire uicc_pkg::crc_ctrl_t ctrl,
  input  wire logic [7:0]          data_byte,
  output logic      [31:0]         crc
);
  import uicc_pkg::*;

  // load the init value or fold one byte
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      crc <= CRC_INIT;
    end else if (ctrl.en) begin
      crc <= crc_byte(crc, data_byte);
    end
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the firmware image crc-32/mpeg-2 checker
module tb_top;
  import uicc_pkg::*;

  localparam int unsigned BUF_DEPTH    = 8192;
  localparam int unsigned RANDOM_BEATS = 1450;
  localparam int unsigned TAIL_CYCLES  = BUF_DEPTH + 100;
  localparam int unsigned CALM_LEVEL   = 120;
  localparam int unsigned SHOW_FAULTS  = 10;

  typedef struct packed {
    logic [15:0] index;
    logic [15:0] length;
    logic [7:0]  data;
  } image_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rx_word;
    logic [31:0] calc_word;
  } crc_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] write_index = '0;
  logic [15:0] image_length = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] received_crc;
  logic [31:0] computed_crc;

  // planned beats, and verdicts still owed by the block
  image_beat_t  pending_beats[$];
  crc_verdict_t verdicts_due[$];

  // entries the plan has written, and the predictor's copy of the buffer
  bit          planned_written [BUF_DEPTH];
  logic [7:0]  image_mirror [BUF_DEPTH];

  int unsigned beats_planned = 0;
  int unsigned beats_taken = 0;
  int unsigned longest_image = 0;
  longint      cycle_budget = 0;
  longint      cycle_limit = 64'd50_000_000;
  longint      cycle_count = 0;
  int unsigned fault_count = 0;
  int unsigned n_match = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_short = 0;

  // idle control for both channels
  int unsigned idle_odds = 0;
  int unsigned hold_odds = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        calm = 1'b0;

  upgrade_image_crc_check_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .write_index  (write_index),
    .image_length (image_length),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .received_crc (received_crc),
    .computed_crc (computed_crc)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // msb-first crc-32 update by one byte, one bit at a time
  function automatic logic [31:0] crc_mpeg2_byte(input logic [31:0] acc, input logic [7:0] octet);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[31] ^ octet[k];
      r = {r[30:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void note_fault(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    fault_count++;
    if (fault_count <= SHOW_FAULTS) begin
      $display("mismatch on %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_count);
    end
  endfunction

  // store the byte and work out the verdict this beat owes, if any
  function automatic void predict_beat(input logic [15:0] idx, input logic [15:0] len,
                                       input logic [7:0] data);
    int unsigned  slot;
    int unsigned  size;
    crc_verdict_t v;
    slot = (idx >= BUF_DEPTH) ? BUF_DEPTH - 1 : int'(idx);
    size = len;
    image_mirror[slot] = data;
    if (size == 0 || slot != size - 1) begin
      return;
    end
    if (size < 4) begin
      v.status    = STATUS_TOO_SHORT;
      v.rx_word   = '0;
      v.calc_word = '0;
    end else begin
      v.rx_word = {image_mirror[size - 1], image_mirror[size - 2],
                   image_mirror[size - 3], image_mirror[size - 4]};
      v.calc_word = CRC_INIT;
      for (int unsigned i = 0; i < size - 4; i++) begin
        v.calc_word = crc_mpeg2_byte(v.calc_word, image_mirror[i]);
      end
      v.status = (v.calc_word == v.rx_word) ? STATUS_MATCH : STATUS_MISMATCH;
    end
    verdicts_due.push_back(v);
  endfunction

  // queue one beat; a completion that would read unwritten entries gets a harmless length
  task automatic plan_beat(input int unsigned idx, input int unsigned len, input logic [7:0] data);
    int unsigned slot;
    bit          done;
    image_beat_t b;
    slot = (idx >= BUF_DEPTH) ? BUF_DEPTH - 1 : idx;
    planned_written[slot] = 1'b1;
    done = (len != 0) && (slot == len - 1);
    if (done && len >= 4) begin
      for (int unsigned i = 0; i < len; i++) begin
        if (!planned_written[i]) begin
          done = 1'b0;
        end
      end
      if (!done) begin
        len = slot;
      end
    end
    b.index  = idx[15:0];
    b.length = len[15:0];
    b.data   = data;
    pending_beats.push_back(b);
    beats_planned++;
    cycle_budget += 8;
    if (done) begin
      cycle_budget += len + 16;
      if (len > longest_image) begin
        longest_image = len;
      end
    end
  endtask

  // image: payload then its crc, little-endian, one crc bit flipped if corrupt; keep cuts the sequence short
  task automatic plan_image(input int unsigned len, input bit corrupt, input int unsigned keep);
    logic [31:0] crc;
    logic [7:0]  b;
    int unsigned fill_mode;
    int unsigned idx;
    crc = CRC_INIT;
    fill_mode = $urandom_range(7);
    for (int unsigned i = 0; i < len - 4; i++) begin
      b = (fill_mode == 0) ? 8'h00 : (fill_mode == 1) ? 8'hFF : 8'($urandom);
      crc = crc_mpeg2_byte(crc, b);
      if (i < keep) begin
        plan_beat(i, len, b);
      end
    end
    if (corrupt) begin
      crc = crc ^ (32'h1 << $urandom_range(31));
    end
    for (int unsigned k = 0; k < 4; k++) begin
      idx = len - 4 + k;
      if (idx < keep) begin
        // the last byte of a full-depth image may come with an index past the buffer
        if (idx == BUF_DEPTH - 1 && $urandom_range(1) == 1) begin
          idx = $urandom_range(65535, BUF_DEPTH - 1);
        end
        plan_beat(idx, len, crc[8*k +: 8]);
      end
    end
  endtask

  // input driver: holds a beat while stalled, idles in bursts
  always @(posedge clk) begin : beat_driver
    image_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(write_index, image_length, data_byte);
        beats_taken++;
        if (beats_taken % 64 == 0) begin
          idle_odds <= 15 * $urandom_range(3);
          hold_odds <= 15 * $urandom_range(3);
        end
      end
      calm <= (pending_beats.size() < CALM_LEVEL);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !calm) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_beats.size() != 0 &&
                     (calm || $urandom_range(99) >= idle_odds)) begin
          nxt = pending_beats.pop_front();
          in_valid     <= 1'b1;
          write_index  <= nxt.index;
          image_length <= nxt.length;
          data_byte    <= nxt.data;
          gap_left     <= 0;
        end else if (pending_beats.size() != 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(5);
        end else begin
          in_valid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // result monitor and output stall bursts
  always @(posedge clk) begin : verdict_monitor
    crc_verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          note_fault("unexpected result beat", 32'h0, {30'd0, status});
        end else begin
          want = verdicts_due.pop_front();
          if (status !== want.status) begin
            note_fault("status", {30'd0, want.status}, {30'd0, status});
          end
          if (received_crc !== want.rx_word) begin
            note_fault("received_crc", want.rx_word, received_crc);
          end
          if (computed_crc !== want.calc_word) begin
            note_fault("computed_crc", want.calc_word, computed_crc);
          end
          case (want.status)
            STATUS_MATCH:    n_match++;
            STATUS_MISMATCH: n_mismatch++;
            default:         n_short++;
          endcase
        end
      end
      if (hold_left != 0 && !calm) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!calm && $urandom_range(99) < hold_odds) begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(5);
      end else begin
        out_stall <= 1'b0;
        hold_left <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d of %0d beats taken, %0d results owed",
               cycle_count, beats_taken, beats_planned, verdicts_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned idx;

    // directed: too-short lengths, clamped writes, smallest images, match and mismatch
    plan_beat(0, 1, 8'h00);
    plan_beat(1, 2, 8'hFF);
    plan_beat(2, 3, 8'h5A);
    plan_beat(16'hFFFF, 0, 8'hA5);
    plan_beat(BUF_DEPTH, 16'hFFFF, 8'h3C);
    plan_beat(3, 4, 8'hC3);
    plan_image(4, 1'b0, 4);
    plan_image(5, 1'b0, 5);
    plan_image(9, 1'b1, 9);

    // random: mostly whole images, some abandoned, too-short, rechecks and noise
    while (beats_planned < RANDOM_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = (pick < 44) ? $urandom_range(24, 4) :
              (pick < 52 || beats_planned + 1024 > RANDOM_BEATS) ? $urandom_range(200, 25) :
              $urandom_range(1024, 201);
        plan_image(len, $urandom_range(3) == 0, len);
      end else if (pick < 65) begin
        len = $urandom_range(40, 5);
        plan_image(len, 1'b0, $urandom_range(len - 1, 1));
      end else if (pick < 75) begin
        len = $urandom_range(3, 1);
        plan_beat(len - 1, len, 8'($urandom));
      end else if (pick < 80) begin
        len = ($urandom_range(4) != 0) ? $urandom_range(64, 4) : $urandom_range(BUF_DEPTH, 4);
        idx = (len == BUF_DEPTH) ? $urandom_range(65535, BUF_DEPTH - 1) : len - 1;
        plan_beat(idx, len, 8'($urandom));
      end else begin
        idx = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(63);
        len = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(64);
        plan_beat(idx, len, 8'($urandom));
      end
    end
    cycle_limit = 4 * cycle_budget + 4 * TAIL_CYCLES;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken != beats_planned || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d image beats, longest checked image %0d bytes",
             beats_taken, longest_image);
    $display("results checked: %0d match, %0d mismatch, %0d too short; %0d faults",
             n_match, n_mismatch, n_short, fault_count);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/uicc_pkg.sv
rtl/core/uicc_ram.sv
rtl/core/uicc_crc_unit.sv
rtl/core/upgrade_image_crc_check_top.sv
sim/tb_top.sv
